@@ design/ptt_pkg.sv @@
`timescale 1ns / 1ps
// ptt_pkg: shared types and constants for the periodic task timer table
// no dependencies; used by the interfaces, the table memory and the top level

package ptt_pkg;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned REQ_W    = 2;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_TICK   = 2'd3
  } req_e;

  // one table entry as held in the memory
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   start;
    logic [PERIOD_W-1:0] period;
  } entry_t;

  // one response beat
  typedef struct packed {
    logic            fired;
    logic [ID_W-1:0] fired_task_id;
    logic            status;
  } rsp_t;

endpackage

@@ design/ptt_req_if.sv @@
`timescale 1ns / 1ps
// ptt_req_if: request channel (valid/ready plus request payload)
// depends on ptt_pkg for field widths

interface ptt_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptt_pkg::REQ_W-1:0]     req_type;
  logic [ptt_pkg::ID_W-1:0]      task_id_in;
  logic [ptt_pkg::TIME_W-1:0]    new_start_time;
  logic [ptt_pkg::PERIOD_W-1:0]  new_period;
  logic [ptt_pkg::TIME_W-1:0]    now_time;

  modport source (output valid, req_type, task_id_in, new_start_time, new_period, now_time,
                  input ready);
  modport sink   (input valid, req_type, task_id_in, new_start_time, new_period, now_time,
                  output ready);
endinterface

@@ design/ptt_rsp_if.sv @@
`timescale 1ns / 1ps
// ptt_rsp_if: response channel (valid/ready plus response payload)
// depends on ptt_pkg for field widths

interface ptt_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     fired;
  logic [ptt_pkg::ID_W-1:0] fired_task_id;
  logic                     status;

  modport source (output valid, fired, fired_task_id, status, input ready);
  modport sink   (input valid, fired, fired_task_id, status, output ready);
endinterface

@@ design/ptt_table_mem.sv @@
`timescale 1ns / 1ps
// ptt_table_mem: task table storage, one write and one registered read a cycle
// depends on ptt_pkg for the entry type

module ptt_table_mem #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  ptt_pkg::entry_t          wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output ptt_pkg::entry_t          rdata_o
);
  import ptt_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/periodic_task_timer_table.sv @@
`timescale 1ns / 1ps
// periodic_task_timer_table: top level, sequencer around one table memory
// depends on ptt_pkg, ptt_req_if, ptt_rsp_if and ptt_table_mem
//
// Usage
//   req_i carries one request a beat: add a task, remove the first task with an
//   id, clear the table, or a time tick with the current time. rsp_o returns
//   exactly one beat per request: fired/fired_task_id on a tick that dispatched
//   the earliest due task, status set when an add met a full table.
//   The scan reads the table memory one entry a cycle through its single
//   registered read port, so a remove or a tick on a non-empty table waits
//   for a pass over all held entries; a tick then goes through S_FIRE for
//   the saturating start time update. Add, clear, and a remove or tick on an
//   empty table are answered straight from idle. A new request is taken once
//   the sequencer is idle and the response register is free or being drained
//   in that cycle. A stalled receiver holds the response register and so
//   stops new requests. Reset empties the table and the response register;
//   table contents are not cleared, only the entry count.

module periodic_task_timer_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptt_req_if.sink    req_i,
  ptt_rsp_if.source  rsp_o
);
  import ptt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_TICK   = 4'b0010,
    S_FIRE   = 4'b0100,
    S_REMOVE = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic                issue_q, issue_d;
  logic                rvalid_q;
  logic [IDX_W-1:0]    ridx_q;
  logic                found_q, found_d;
  entry_t              best_q, best_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_q, out_d;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;
  logic                mem_re;
  entry_t              mem_rdata;

  logic                req_ready;
  logic                scanning;
  logic                last_read;
  logic                last_data;
  logic [TIME_W:0]     next_sum;
  logic [TIME_W-1:0]   next_start;

  ptt_table_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  // scan bookkeeping
  assign scanning  = (state_q == S_TICK) || (state_q == S_REMOVE);
  assign last_read = (CNT_W'(rd_ptr_q) + CNT_W'(1)) == count_q;
  assign last_data = (CNT_W'(ridx_q) + CNT_W'(1)) == count_q;

  // saturating advance of the selected start time
  assign next_sum   = {1'b0, best_q.start} + (TIME_W + 1)'(best_q.period);
  assign next_start = next_sum[TIME_W] ? {TIME_W{1'b1}} : next_sum[TIME_W-1:0];

  assign req_ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    issue_d     = issue_q;
    found_d     = found_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    id_d        = id_q;
    now_d       = now_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;

    // read issue, one entry a cycle
    if (scanning && issue_q) begin
      mem_re = 1'b1;
      if (last_read) begin
        issue_d = 1'b0;
      end else begin
        rd_ptr_d = rd_ptr_q + IDX_W'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_ready && req_i.valid) begin
          id_d     = req_i.task_id_in;
          now_d    = req_i.now_time;
          rd_ptr_d = '0;
          issue_d  = 1'b1;
          found_d  = 1'b0;
          out_d    = '0;
          unique case (req_e'(req_i.req_type))
            REQ_ADD: begin
              out_valid_d = 1'b1;
              if (count_q == CNT_W'(TABLE_DEPTH)) begin
                out_d.status = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IDX_W-1:0];
                mem_wdata = '{id: req_i.task_id_in, start: req_i.new_start_time,
                              period: req_i.new_period};
                count_d   = count_q + CNT_W'(1);
              end
            end
            REQ_CLEAR: begin
              out_valid_d = 1'b1;
              count_d     = '0;
            end
            REQ_REMOVE: begin
              if (count_q == '0) out_valid_d = 1'b1;
              else               state_d     = S_REMOVE;
            end
            REQ_TICK: begin
              if (count_q == '0) out_valid_d = 1'b1;
              else               state_d     = S_TICK;
            end
            default: ;
          endcase
        end
      end

      // track the earliest start, first entry wins ties
      S_TICK: begin
        if (rvalid_q) begin
          if ((ridx_q == '0) || (mem_rdata.start < best_q.start)) begin
            best_d     = mem_rdata;
            best_idx_d = ridx_q;
          end
          if (last_data) state_d = S_FIRE;
        end
      end

      // dispatch when due and write back the advanced start
      S_FIRE: begin
        out_valid_d = 1'b1;
        out_d       = '0;
        if (best_q.start <= now_q) begin
          mem_we              = 1'b1;
          mem_waddr           = best_idx_q;
          mem_wdata           = best_q;
          mem_wdata.start     = next_start;
          out_d.fired         = 1'b1;
          out_d.fired_task_id = best_q.id;
        end
        state_d = S_IDLE;
      end

      // find the first match, then close up the later entries
      S_REMOVE: begin
        if (rvalid_q) begin
          if (found_q) begin
            mem_we    = 1'b1;
            mem_waddr = ridx_q - IDX_W'(1);
            mem_wdata = mem_rdata;
          end else if (mem_rdata.id == id_q) begin
            found_d = 1'b1;
          end
          if (last_data) begin
            if (found_q || (mem_rdata.id == id_q)) count_d = count_q - CNT_W'(1);
            out_valid_d = 1'b1;
            out_d       = '0;
            state_d     = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= 1'b0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      rvalid_q    <= mem_re;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_ptr_q   <= rd_ptr_d;
    ridx_q     <= rd_ptr_q;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    id_q       <= id_d;
    now_q      <= now_d;
    out_q      <= out_d;
  end

  assign req_i.ready         = req_ready;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.fired         = out_q.fired;
  assign rsp_o.fired_task_id = out_q.fired_task_id;
  assign rsp_o.status        = out_q.status;

endmodule

@@ design/ptt_checker.sv @@
`timescale 1ns / 1ps
// ptt_checker: port-level checks on the periodic task timer table
// depends on ptt_req_if and ptt_rsp_if; bound to periodic_task_timer_table

module ptt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  ptt_req_if.sink   req_i,
  ptt_rsp_if.source rsp_o
);

  logic req_beat;
  logic rsp_beat;
  logic pending_q;

  assign req_beat = req_i.valid && req_i.ready;
  assign rsp_beat = rsp_o.valid && rsp_o.ready;

  // one request in flight until its response beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (req_beat) begin
      pending_q <= 1'b1;
    end else if (rsp_beat) begin
      pending_q <= 1'b0;
    end
  end

  // a response beat only answers an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> pending_q)
    else $error("response without an outstanding request");

  // no second request before the first one is answered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_beat |-> (!pending_q || rsp_beat))
    else $error("request accepted while another is outstanding");

  // a stalled response holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=>
      (rsp_o.valid && $stable(rsp_o.fired) && $stable(rsp_o.fired_task_id) &&
       $stable(rsp_o.status)))
    else $error("stalled response changed");

  // a dropped add never dispatches, and no id is shown without a dispatch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (!(rsp_o.fired && rsp_o.status) &&
                     (rsp_o.fired || (rsp_o.fired_task_id == '0))))
    else $error("inconsistent response fields");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for periodic_task_timer_table, with a driver and a monitor
// that keep a copy of the task table and predict every response beat
// depends on ptt_pkg, ptt_req_if, ptt_rsp_if and the design top level

module tb;
  import ptt_pkg::*;

  localparam int unsigned    DEPTH          = 16;
  localparam int unsigned    WATCHDOG_LIMIT = 1000;
  localparam int unsigned    RANDOM_ITEMS   = 1200;
  localparam int unsigned    QUIET_TAIL     = 150;
  localparam [TIME_W-1:0]    TIME_MAX       = '1;

  typedef struct {
    req_e                kind;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   start;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   now;
    bit                  drain_first;
  } req_item_t;

  logic clk_i;
  logic rst_ni;

  ptt_req_if req_bus ();
  ptt_rsp_if rsp_bus ();

  periodic_task_timer_table #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // requests waiting to be sent and responses still owed by the block
  req_item_t req_backlog_q[$];
  rsp_t      awaited_rsp_q[$];

  // bench copy of the task table
  logic [ID_W-1:0]     slot_id[DEPTH];
  logic [TIME_W-1:0]   slot_start[DEPTH];
  logic [PERIOD_W-1:0] slot_period[DEPTH];
  int                  slots_held = 0;

  int mismatch_count = 0;
  int req_beats      = 0;
  int send_gap       = 0;
  int stall_left     = 0;
  int quiet_cycles   = 0;

  // generator state
  logic [TIME_W-1:0] gen_now;
  bit                gen_big_period;
  bit                drain_next;
  logic [ID_W-1:0]   recent_ids[$];

  // clock and known values on every block input from time zero
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    req_bus.valid  = 1'b0;
    req_bus.req_type       = '0;
    req_bus.task_id_in     = '0;
    req_bus.new_start_time = '0;
    req_bus.new_period     = '0;
    req_bus.now_time       = '0;
    rsp_bus.ready  = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // apply one request to the table copy and return the response it must give
  function automatic rsp_t resolve_request(req_e kind, logic [ID_W-1:0] id,
                                           logic [TIME_W-1:0] start,
                                           logic [PERIOD_W-1:0] period,
                                           logic [TIME_W-1:0] now);
    rsp_t            r;
    int              pick;
    int              k;
    logic [TIME_W:0] advanced;
    r = '0;
    case (kind)
      REQ_ADD: begin
        if (slots_held == DEPTH) begin
          r.status = 1'b1;
        end else begin
          slot_id[slots_held]     = id;
          slot_start[slots_held]  = start;
          slot_period[slots_held] = period;
          slots_held++;
        end
      end
      REQ_REMOVE: begin
        pick = -1;
        for (k = 0; k < slots_held; k++)
          if (pick < 0 && slot_id[k] == id) pick = k;
        // close up behind the first match, order kept
        if (pick >= 0) begin
          for (k = pick; k < slots_held - 1; k++) begin
            slot_id[k]     = slot_id[k+1];
            slot_start[k]  = slot_start[k+1];
            slot_period[k] = slot_period[k+1];
          end
          slots_held--;
        end
      end
      REQ_CLEAR: begin
        slots_held = 0;
      end
      default: begin
        if (slots_held != 0) begin
          // earliest start wins, ties to the oldest entry
          pick = 0;
          for (k = 1; k < slots_held; k++)
            if (slot_start[k] < slot_start[pick]) pick = k;
          if (slot_start[pick] <= now) begin
            advanced         = {1'b0, slot_start[pick]} +
                               {{(TIME_W + 1 - PERIOD_W){1'b0}}, slot_period[pick]};
            slot_start[pick] = advanced[TIME_W] ? TIME_MAX : advanced[TIME_W-1:0];
            r.fired          = 1'b1;
            r.fired_task_id  = slot_id[pick];
          end
        end
      end
    endcase
    return r;
  endfunction

  // idling only away from the tail and outside the quiet windows
  function automatic bit idling_on();
    return req_backlog_q.size() > QUIET_TAIL && ((req_beats / 128) % 4) != 3;
  endfunction

  function automatic logic [TIME_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] sat_add48(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  task automatic push_req(req_e kind, logic [ID_W-1:0] id, logic [TIME_W-1:0] start,
                          logic [PERIOD_W-1:0] period, logic [TIME_W-1:0] now);
    req_item_t it;
    it.kind        = kind;
    it.id          = id;
    it.start       = start;
    it.period      = period;
    it.now         = now;
    it.drain_first = drain_next || ($urandom_range(0, 79) == 0);
    drain_next     = 1'b0;
    req_backlog_q.insert(req_backlog_q.size(), it);
  endtask

  // add a task close to the running time, ids often reused
  task automatic gen_add();
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   start;
    logic [PERIOD_W-1:0] period;
    id     = ($urandom_range(0, 1) == 0) ? ID_W'($urandom_range(0, 7))
                                         : ID_W'($urandom_range(0, 16'hFFFF));
    start  = ($urandom_range(0, 9) == 0) ? rand48()
                                         : sat_add48(gen_now, TIME_W'($urandom_range(0, 60)));
    period = gen_big_period ? $urandom : $urandom_range(0, 40);
    recent_ids.insert(recent_ids.size(), id);
    if (recent_ids.size() > 32) recent_ids.delete(0);
    push_req(REQ_ADD, id, start, period, rand48());
  endtask

  // stimulus: directed opening, then epochs of adds, ticks and removes
  initial begin
    int pick;
    int i;
    drain_next = 1'b0;
    gen_now    = '0;

    // tick on an empty table
    push_req(REQ_TICK, ID_W'($urandom), rand48(), $urandom, TIME_MAX);
    // two tasks due at the same time, plus a duplicate id
    push_req(REQ_ADD, 16'hFFFF, '0, 32'hFFFF_FFFF, rand48());
    push_req(REQ_ADD, 16'h1234, '0, 32'd5, rand48());
    push_req(REQ_ADD, 16'hFFFF, 48'd3, 32'd1, rand48());
    push_req(REQ_TICK, ID_W'($urandom), rand48(), $urandom, '0);
    push_req(REQ_TICK, ID_W'($urandom), rand48(), $urandom, 48'd2);
    // tick before the earliest start
    push_req(REQ_TICK, ID_W'($urandom), rand48(), $urandom, 48'd2);
    // remove first of the duplicates, then an id that is not held
    push_req(REQ_REMOVE, 16'hFFFF, rand48(), $urandom, rand48());
    push_req(REQ_REMOVE, 16'h0000, rand48(), $urandom, rand48());
    push_req(REQ_CLEAR, ID_W'($urandom), rand48(), $urandom, rand48());
    // start time saturates at the top of the range
    push_req(REQ_ADD, 16'h0000, TIME_MAX - 1, 32'hFFFF_FFFF, rand48());
    push_req(REQ_TICK, ID_W'($urandom), rand48(), $urandom, TIME_MAX);
    // fill the table and overflow it
    for (i = 1; i < DEPTH; i++)
      push_req(REQ_ADD, ID_W'(i), rand48(), $urandom, rand48());
    push_req(REQ_ADD, 16'hABCD, rand48(), $urandom, rand48());

    drain_next = 1'b1;
    while (req_backlog_q.size() < RANDOM_ITEMS + 27) begin
      case ($urandom_range(0, 9))
        0, 1:    gen_now = rand48();
        2, 3:    gen_now = TIME_MAX - TIME_W'($urandom_range(0, 4000));
        default: gen_now = TIME_W'($urandom_range(0, 100000));
      endcase
      gen_big_period = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0)
        push_req(REQ_CLEAR, ID_W'($urandom), rand48(), $urandom, rand48());
      repeat ($urandom_range(1, 18)) gen_add();
      repeat ($urandom_range(10, 40)) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          if ($urandom_range(0, 9) == 0) begin
            push_req(REQ_TICK, ID_W'($urandom), rand48(), $urandom, rand48());
          end else begin
            gen_now = sat_add48(gen_now, TIME_W'($urandom_range(0, 15)));
            push_req(REQ_TICK, ID_W'($urandom), rand48(), $urandom, gen_now);
          end
        end else if (pick < 70) begin
          gen_add();
        end else if (pick < 85) begin
          if (recent_ids.size() != 0 && $urandom_range(0, 4) != 0)
            push_req(REQ_REMOVE, recent_ids[$urandom_range(0, recent_ids.size() - 1)],
                     rand48(), $urandom, rand48());
          else
            push_req(REQ_REMOVE, ID_W'($urandom), rand48(), $urandom, rand48());
        end else if (pick < 87) begin
          push_req(REQ_CLEAR, ID_W'($urandom), rand48(), $urandom, rand48());
        end else begin
          // noise: every field random
          push_req(req_e'($urandom_range(0, 3)), ID_W'($urandom), rand48(), $urandom,
                   rand48());
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog_q.size() != 0 || awaited_rsp_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // request driver: predict on each accepted beat, then present the next one
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    bit   accepted;
    bit   present;
    rsp_t predicted;
    if (!rst_ni) begin
      req_bus.valid          <= 1'b0;
      req_bus.req_type       <= '0;
      req_bus.task_id_in     <= '0;
      req_bus.new_start_time <= '0;
      req_bus.new_period     <= '0;
      req_bus.now_time       <= '0;
      send_gap = 0;
    end else begin
      accepted = req_bus.valid && req_bus.ready;
      present  = 1'b0;
      if (accepted) begin
        predicted = resolve_request(req_e'(req_bus.req_type), req_bus.task_id_in,
                                    req_bus.new_start_time, req_bus.new_period,
                                    req_bus.now_time);
        awaited_rsp_q.insert(awaited_rsp_q.size(), predicted);
        req_backlog_q.delete(0);
        req_beats++;
      end
      if (req_bus.valid && !accepted) begin
        present = 1'b1;
      end else if (send_gap != 0) begin
        send_gap--;
      end else if (req_backlog_q.size() != 0 &&
                   !(req_backlog_q[0].drain_first && awaited_rsp_q.size() != 0)) begin
        if (idling_on() && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 12);
        end else begin
          present                = 1'b1;
          req_bus.req_type       <= req_backlog_q[0].kind;
          req_bus.task_id_in     <= req_backlog_q[0].id;
          req_bus.new_start_time <= req_backlog_q[0].start;
          req_bus.new_period     <= req_backlog_q[0].period;
          req_bus.now_time       <= req_backlog_q[0].now;
        end
      end
      req_bus.valid <= present;
    end
  end

  // response monitor: check each beat against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : rsp_monitor
    rsp_t want;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (awaited_rsp_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: response beat with none owed: fired=%0d id=%h status=%0d",
                     $realtime, rsp_bus.fired, rsp_bus.fired_task_id, rsp_bus.status);
        end else begin
          want = awaited_rsp_q.pop_front();
          if (rsp_bus.fired !== want.fired || rsp_bus.fired_task_id !== want.fired_task_id ||
              rsp_bus.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: exp fired=%0d id=%h status=%0d, got fired=%0d id=%h status=%0d",
                       $realtime, want.fired, want.fired_task_id, want.status,
                       rsp_bus.fired, rsp_bus.fired_task_id, rsp_bus.status);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ periodic_task_timer_table.f @@
design/ptt_pkg.sv
design/ptt_req_if.sv
design/ptt_rsp_if.sv
design/ptt_table_mem.sv
design/periodic_task_timer_table.sv
design/ptt_checker.sv
tb/tb.sv
